// ===== rtl/core/lmat_pkg.sv =====
// Shared constants and types of the local mean adaptive threshold block.
package lmat_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;
    localparam int MAX_RADIUS = 63;

    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int LINE_W   = $clog2(2 * MAX_RADIUS + 2);
    localparam int RING_AW  = LINE_W + COL_W;
    localparam int HIST_AW  = LINE_W;
    localparam int FIFO_DEPTH = 4;

    localparam int WIDTH_W  = 12;
    localparam int HEIGHT_W = 13;
    localparam int RAD_W    = 6;
    localparam int OFF_W    = 10;
    localparam int CFG_W    = 13;
    localparam int CFG_AW   = 3;

    localparam int COLSUM_W = 15;
    localparam int TOTAL_W  = 22;
    localparam int AREA_W   = 14;
    localparam int PROD_W   = 26;

    typedef enum logic [CFG_AW-1:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_WINDOW_RAD   = 3'd2,
        REG_MEAN_OFFSET  = 3'd3,
        REG_VALUE_ABOVE  = 3'd4,
        REG_VALUE_BELOW  = 3'd5
    } cfg_index_t;

    // Control of one window step between the address stage and the update stage.
    typedef struct packed {
        logic               valid;
        logic               emit;
        logic               last;
        logic [COL_W-1:0]   lx;
        logic [HIST_AW-1:0] hist_addr;
        logic               first_row;
        logic               add_en;
        logic [7:0]         pixel;
        logic               old_en;
        logic               sub_en;
        logic               start;
        logic               start_acc;
        logic               add_col;
        logic               acc_en;
        logic               acc_first;
        logic [AREA_W-1:0]  area;
    } step_ctl_t;

endpackage

// ===== rtl/core/local_mean_adaptive_threshold.sv =====
// Local mean adaptive threshold over a clipped square box window, streamed in raster order.
//
// Pixels enter on the s_ channel: s_tdata carries the grey level, s_tuser marks a drain
// request (1) or a pixel request (0). Results leave on the m_ channel: m_tdata carries the
// binarized value, m_tlast marks the final pixel of a frame.
// The decision for pixel (r,c) is made when the input at raster index r*W+c+R*W+R is
// taken; drain requests sent after the frame push out the remaining R*W+R results.
// Drain requests sent before the frame is complete are consumed without a result.
// One request is taken per clock while the output queue has room; the single write port
// of the line ring and of the column sum memory, each touched once per request, sets the rate.
// A result goes through the address stage, the update stage and the output queue to m_tvalid.
// Column sums are updated in place (read, add the entering pixel, subtract the leaving
// one, write back) and need no clearing: the first row of a frame reads them as zero.
// A four entry output queue parts the two sides; when the receiver stalls, requests are
// still taken until the queue and the requests in flight fill it.
// Reset (aresetn low at a clock edge) restores the register defaults and starts a new
// frame. A write to the width, height or radius register also starts a new frame.
module local_mean_adaptive_threshold (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // pixel[7:0]
    input  logic                         s_tuser,   // action[0]
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [7:0]                   m_tdata,   // out_value[7:0]
    output logic                         m_tlast,
    input  logic                         cfg_wr_en,
    input  logic [lmat_pkg::CFG_AW-1:0]  cfg_addr,
    input  logic [lmat_pkg::CFG_W-1:0]   cfg_wr_data
);
    import lmat_pkg::*;

    logic [WIDTH_W-1:0]  frame_width_reg;
    logic [HEIGHT_W-1:0] frame_height_reg;
    logic [RAD_W-1:0]    window_radius_reg;
    logic [OFF_W-1:0]    mean_offset_reg;
    logic [7:0]          value_above_reg;
    logic [7:0]          value_below_reg;
    logic                geom_wr;

    logic [COL_W-1:0]    lx_reg;
    logic [13:0]         ly_reg;
    logic [11:0]         r_reg;
    logic [COL_W-1:0]    c_reg;
    logic                started_reg;
    logic [HIST_AW-1:0]  hist_ptr_reg;

    logic [7:0]          ring_mem [2**RING_AW];
    logic [COLSUM_W-1:0] colsum_mem [MAX_WIDTH];
    logic [COLSUM_W-1:0] hist_mem [2**HIST_AW];
    logic [7:0]          old_pix_q;
    logic [7:0]          ctr_pix_q;
    logic [COLSUM_W-1:0] colsum_q;
    logic [COLSUM_W-1:0] hist_q;

    step_ctl_t           s1_reg;
    step_ctl_t           s1_next;

    logic [COLSUM_W-1:0] prev_col_reg;
    logic [TOTAL_W-1:0]  acc_reg;
    logic [TOTAL_W-1:0]  acc_next;
    logic [TOTAL_W-1:0]  total_reg;
    logic [TOTAL_W-1:0]  total_next;

    logic                s2_valid_reg;
    logic                s2_last_reg;
    logic signed [PROD_W-1:0] s2_prod_reg;
    logic [TOTAL_W-1:0]  s2_total_reg;

    logic [8:0]          fifo_mem [FIFO_DEPTH];
    logic [1:0]          fifo_wr_reg;
    logic [1:0]          fifo_rd_reg;
    logic [2:0]          fifo_cnt_reg;

    logic [WIDTH_W-1:0]  wc;
    logic [HEIGHT_W-1:0] hc;
    logic [6:0]          two_r;
    logic [6:0]          two_r1;
    logic                accept;
    logic                ly_in_frame;
    logic                lead;
    logic                pix_wr;
    logic                emit;
    logic                row_end;
    logic                col_end;
    logic                frame_end;
    logic [12:0]         rlo;
    logic [12:0]         rhi;
    logic [12:0]         row_cnt;
    logic [11:0]         clo;
    logic [11:0]         chi;
    logic [11:0]         col_cnt;
    logic [12:0]         lx_plus_w;
    logic [RING_AW-1:0]  wr_addr;
    logic [RING_AW-1:0]  old_addr;
    logic [RING_AW-1:0]  ctr_addr;
    logic [LINE_W-1:0]   old_row;

    logic [COLSUM_W-1:0] old_col;
    logic [COLSUM_W:0]   col_sum16;
    logic [COLSUM_W-1:0] new_col;
    logic [COLSUM_W-1:0] hist_sub;
    logic signed [10:0]  p_off;
    logic signed [PROD_W-1:0] prod;
    logic                fifo_wr;
    logic                fifo_rd;
    logic [1:0]          in_flight;

    // Geometry is saturated into the range the storage supports.
    always_comb begin
        priority if (frame_width_reg == '0) begin
            wc = WIDTH_W'(1);
        end else if (frame_width_reg > WIDTH_W'(MAX_WIDTH)) begin
            wc = WIDTH_W'(MAX_WIDTH);
        end else begin
            wc = frame_width_reg;
        end
        priority if (frame_height_reg == '0) begin
            hc = HEIGHT_W'(1);
        end else if (frame_height_reg > HEIGHT_W'(MAX_HEIGHT)) begin
            hc = HEIGHT_W'(MAX_HEIGHT);
        end else begin
            hc = frame_height_reg;
        end
    end

    assign two_r  = {window_radius_reg, 1'b0};
    assign two_r1 = {window_radius_reg, 1'b1};

    assign geom_wr = cfg_wr_en && (cfg_addr == REG_FRAME_WIDTH ||
                                   cfg_addr == REG_FRAME_HEIGHT ||
                                   cfg_addr == REG_WINDOW_RAD);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg   <= WIDTH_W'(640);
            frame_height_reg  <= HEIGHT_W'(480);
            window_radius_reg <= RAD_W'(7);
            mean_offset_reg   <= '0;
            value_above_reg   <= 8'd255;
            value_below_reg   <= 8'd0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_FRAME_WIDTH:  frame_width_reg   <= cfg_wr_data[WIDTH_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg  <= cfg_wr_data[HEIGHT_W-1:0];
                REG_WINDOW_RAD:   window_radius_reg <= cfg_wr_data[RAD_W-1:0];
                REG_MEAN_OFFSET:  mean_offset_reg   <= cfg_wr_data[OFF_W-1:0];
                REG_VALUE_ABOVE:  value_above_reg   <= cfg_wr_data[7:0];
                REG_VALUE_BELOW:  value_below_reg   <= cfg_wr_data[7:0];
                default: ;
            endcase
        end
    end

    // The lead position (ly, lx) is the raster position whose column sum is brought up to
    // date by this request; the output position (r, c) trails it by R rows and R columns.
    assign in_flight   = 2'(s1_reg.emit) + 2'(s2_valid_reg);
    assign s_tready    = ({1'b0, fifo_cnt_reg} + {2'b0, in_flight}) < 4'(FIFO_DEPTH);
    assign accept      = s_tvalid && s_tready;
    assign ly_in_frame = ly_reg < {1'b0, hc};
    assign lead        = accept && (!ly_in_frame || !s_tuser);
    assign pix_wr      = lead && ly_in_frame;
    assign emit        = lead && (started_reg ||
                         (ly_reg == {8'd0, window_radius_reg} &&
                          lx_reg == {5'd0, window_radius_reg}));
    assign row_end     = ({1'b0, lx_reg} + 12'd1) == wc;
    assign col_end     = ({1'b0, c_reg} + 12'd1) == wc;
    assign frame_end   = emit && col_end && ({1'b0, r_reg} + 13'd1) == hc;

    always_comb begin
        rlo = (r_reg > {6'd0, window_radius_reg}) ?
              13'({1'b0, r_reg} - {7'd0, window_radius_reg}) : 13'd0;
        rhi = (({1'b0, r_reg} + {7'd0, window_radius_reg}) < hc) ?
              13'({1'b0, r_reg} + {7'd0, window_radius_reg}) : 13'(hc - 13'd1);
        row_cnt = 13'(rhi - rlo + 13'd1);
        clo = (c_reg > {5'd0, window_radius_reg}) ?
              12'({1'b0, c_reg} - {6'd0, window_radius_reg}) : 12'd0;
        chi = (({1'b0, c_reg} + {6'd0, window_radius_reg}) < wc) ?
              12'({1'b0, c_reg} + {6'd0, window_radius_reg}) : 12'(wc - 12'd1);
        col_cnt = 12'(chi - clo + 12'd1);
    end

    assign lx_plus_w = {2'b0, lx_reg} + {1'b0, wc};
    assign old_row   = ly_reg[LINE_W-1:0] - two_r1;
    assign wr_addr   = {ly_reg[LINE_W-1:0], lx_reg};
    assign old_addr  = {old_row, lx_reg};
    assign ctr_addr  = {r_reg[LINE_W-1:0], c_reg};

    always_comb begin
        s1_next.valid     = lead;
        s1_next.emit      = emit;
        s1_next.last      = frame_end;
        s1_next.lx        = lx_reg;
        s1_next.hist_addr = hist_ptr_reg;
        s1_next.first_row = ly_reg == '0;
        s1_next.add_en    = ly_in_frame;
        s1_next.pixel     = s_tdata;
        s1_next.old_en    = ly_reg >= {7'd0, two_r1};
        // The column leaving the window lies 2R+1 steps back, in this row or the one before.
        s1_next.sub_en    = (lx_reg < {5'd0, window_radius_reg}) ?
                            (lx_plus_w > {6'd0, two_r}) : (lx_reg > {4'd0, two_r});
        s1_next.start     = lx_reg == {5'd0, window_radius_reg};
        s1_next.start_acc = window_radius_reg != '0;
        s1_next.add_col   = lx_reg > {5'd0, window_radius_reg};
        s1_next.acc_en    = lx_reg < {5'd0, window_radius_reg};
        s1_next.acc_first = lx_reg == '0;
        s1_next.area      = AREA_W'(row_cnt[6:0] * col_cnt[6:0]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lx_reg       <= '0;
            ly_reg       <= '0;
            r_reg        <= '0;
            c_reg        <= '0;
            started_reg  <= 1'b0;
            hist_ptr_reg <= '0;
        end else if (geom_wr || frame_end) begin
            lx_reg      <= '0;
            ly_reg      <= '0;
            r_reg       <= '0;
            c_reg       <= '0;
            started_reg <= 1'b0;
        end else if (lead) begin
            hist_ptr_reg <= hist_ptr_reg + 1'b1;
            if (row_end) begin
                lx_reg <= '0;
                ly_reg <= ly_reg + 14'd1;
            end else begin
                lx_reg <= lx_reg + 1'b1;
            end
            if (emit) begin
                started_reg <= 1'b1;
                if (col_end) begin
                    c_reg <= '0;
                    r_reg <= r_reg + 12'd1;
                end else begin
                    c_reg <= c_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pix_wr) begin
            ring_mem[wr_addr] <= s_tdata;
        end
        if (lead) begin
            old_pix_q <= ring_mem[old_addr];
            // With a radius of zero the center pixel is the one being written.
            ctr_pix_q <= (pix_wr && ctr_addr == wr_addr) ? s_tdata : ring_mem[ctr_addr];
            colsum_q  <= colsum_mem[lx_reg];
            hist_q    <= hist_mem[hist_ptr_reg - two_r1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg <= '0;
        end else begin
            s1_reg <= s1_next;
        end
    end

    // Update stage: column sum read-modify-write and the running window total.
    always_comb begin
        old_col   = s1_reg.first_row ? '0 : colsum_q;
        col_sum16 = {1'b0, old_col}
                  + (s1_reg.add_en ? {8'd0, s1_reg.pixel} : 16'd0)
                  - (s1_reg.old_en ? {8'd0, old_pix_q} : 16'd0);
        new_col   = col_sum16[COLSUM_W-1:0];
        // With a radius of zero the leaving column is the one just written.
        if (!s1_reg.sub_en) begin
            hist_sub = '0;
        end else if (window_radius_reg == '0) begin
            hist_sub = prev_col_reg;
        end else begin
            hist_sub = hist_q;
        end
        priority if (s1_reg.start) begin
            total_next = (s1_reg.start_acc ? acc_reg : '0) + TOTAL_W'(new_col);
        end else if (s1_reg.add_col) begin
            total_next = total_reg + TOTAL_W'(new_col) - TOTAL_W'(hist_sub);
        end else begin
            total_next = total_reg - TOTAL_W'(hist_sub);
        end
        if (s1_reg.acc_first) begin
            acc_next = TOTAL_W'(new_col);
        end else begin
            acc_next = acc_reg + TOTAL_W'(new_col);
        end
        p_off = $signed({3'b000, ctr_pix_q}) + $signed({mean_offset_reg[OFF_W-1], mean_offset_reg});
        prod  = PROD_W'(p_off * $signed({1'b0, s1_reg.area}));
    end

    always_ff @(posedge aclk) begin
        if (s1_reg.valid) begin
            colsum_mem[s1_reg.lx]      <= new_col;
            hist_mem[s1_reg.hist_addr] <= new_col;
            prev_col_reg               <= new_col;
            total_reg                  <= total_next;
            if (s1_reg.acc_en) begin
                acc_reg <= acc_next;
            end
        end
        s2_prod_reg  <= prod;
        s2_total_reg <= total_next;
        s2_last_reg  <= s1_reg.last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= s1_reg.emit;
        end
    end

    // Output queue.
    assign fifo_wr  = s2_valid_reg;
    assign fifo_rd  = m_tvalid && m_tready;
    assign m_tvalid = fifo_cnt_reg != '0;
    assign m_tdata  = fifo_mem[fifo_rd_reg][7:0];
    assign m_tlast  = fifo_mem[fifo_rd_reg][8];

    always_ff @(posedge aclk) begin
        if (fifo_wr) begin
            fifo_mem[fifo_wr_reg] <= {s2_last_reg,
                (s2_prod_reg > $signed({4'b0000, s2_total_reg})) ? value_above_reg
                                                                 : value_below_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fifo_wr_reg  <= '0;
            fifo_rd_reg  <= '0;
            fifo_cnt_reg <= '0;
        end else begin
            if (fifo_wr) begin
                fifo_wr_reg <= fifo_wr_reg + 1'b1;
            end
            if (fifo_rd) begin
                fifo_rd_reg <= fifo_rd_reg + 1'b1;
            end
            fifo_cnt_reg <= fifo_cnt_reg + 3'(fifo_wr) - 3'(fifo_rd);
        end
    end

`ifndef SYNTHESIS
    a_queue_credit: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, fifo_cnt_reg} + {2'b0, in_flight}) <= 4'(FIFO_DEPTH))
        else $error("output queue credit exceeded");

    a_colsum_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_reg.valid && lead && !geom_wr) |-> (s1_reg.lx != lx_reg))
        else $error("column sum read collides with write back");

    a_frame_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_end |=> (ly_reg == '0 && lx_reg == '0 && !started_reg))
        else $error("counters not cleared after frame end");

    a_emit_reaches_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> ##1 fifo_wr)
        else $error("result lost in pipeline");
`endif

endmodule
